/* hdl/gf22_pkg.sv */
// Shared types, register indexes and GF(2^8) helpers for the 2+2 erasure codec.
package gf22_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaskW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = MaskW;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_CODEC_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PIECE_MASK = 1'b1;

  // Register reset values.
  localparam logic CodecModeReset = 1'b0;
  localparam logic [MaskW-1:0] PieceMaskReset = 4'hF;

  // Operating modes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_RECOVER = 1'b1;

  // Piece mask bit positions.
  localparam int unsigned PieceD0 = 0;
  localparam int unsigned PieceD1 = 1;
  localparam int unsigned PieceP0 = 2;
  localparam int unsigned PieceP1 = 3;

  // Field constants: reduction term, top bit, two, three, and the inverses of three and two.
  localparam logic [ByteW-1:0] GfReduce = 8'h1B;
  localparam logic [ByteW-1:0] GfTopBit = 8'h80;
  localparam logic [ByteW-1:0] GfTwo = 8'h02;
  localparam logic [ByteW-1:0] GfThree = 8'h03;
  localparam logic [ByteW-1:0] GfInvThree = 8'hF6;
  localparam logic [ByteW-1:0] GfInvTwo = 8'h8D;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic mode;
    logic [MaskW-1:0] mask;
  } cfg_t;

  // Multiply by x modulo the field polynomial.
  function automatic logic [ByteW-1:0] gf_dbl(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = {v[ByteW-2:0], 1'b0};
    if ((v & GfTopBit) != '0) begin
      r = r ^ GfReduce;
    end
    return r;
  endfunction

  // Product with a constant factor; unrolls into an XOR network.
  function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] v,
                                              input logic [ByteW-1:0] k);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] term;
    acc = '0;
    term = v;
    for (int i = 0; i < ByteW; i++) begin
      if (k[i]) begin
        acc = acc ^ term;
      end
      term = gf_dbl(term);
    end
    return acc;
  endfunction

endpackage

/* hdl/gf22_cfg.sv */
// Configuration registers: codec mode and piece mask.
module gf22_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [gf22_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [gf22_pkg::CfgDataW-1:0]   cfg_wdata,
  output gf22_pkg::cfg_t                  cfg
);
  import gf22_pkg::*;

  cfg_t cfg_reg;

  // Each write lands in the register selected by its index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.mode <= CodecModeReset;
      cfg_reg.mask <= PieceMaskReset;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CODEC_MODE: cfg_reg.mode <= cfg_wdata[0];
        REG_PIECE_MASK: cfg_reg.mask <= cfg_wdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

/* hdl/gf22_dp.sv */
// Datapath: input register, encode and recover logic, result register.
module gf22_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  gf22_pkg::cfg_t               cfg,
  input  logic [gf22_pkg::ByteW-1:0]   byte_data0,
  input  logic [gf22_pkg::ByteW-1:0]   byte_data1,
  input  logic [gf22_pkg::ByteW-1:0]   byte_parity0,
  input  logic [gf22_pkg::ByteW-1:0]   byte_parity1,
  output logic                         done,
  output logic [gf22_pkg::ByteW-1:0]   out_first,
  output logic [gf22_pkg::ByteW-1:0]   out_second,
  output logic                         too_few_pieces
);
  import gf22_pkg::*;

  // Input stage registers.
  logic             in_valid;
  cfg_t             in_cfg;
  logic [ByteW-1:0] in_d0;
  logic [ByteW-1:0] in_d1;
  logic [ByteW-1:0] in_p0;
  logic [ByteW-1:0] in_p1;

  // Result stage registers.
  logic             res_valid;
  logic [ByteW-1:0] res_first;
  logic [ByteW-1:0] res_second;
  logic             res_flag;

  logic [ByteW-1:0] first_next;
  logic [ByteW-1:0] second_next;
  logic             flag_next;

  logic h0, h1, hp0, hp1;

  // Capture each request together with the configuration it runs under.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cfg <= cfg;
      in_d0  <= byte_data0;
      in_d1  <= byte_data1;
      in_p0  <= byte_parity0;
      in_p1  <= byte_parity1;
    end
  end

  assign h0  = in_cfg.mask[PieceD0];
  assign h1  = in_cfg.mask[PieceD1];
  assign hp0 = in_cfg.mask[PieceP0];
  assign hp1 = in_cfg.mask[PieceP1];

  // Encode computes both parities; recover uses the first usable pair in priority order.
  always_comb begin
    first_next  = '0;
    second_next = '0;
    flag_next   = 1'b0;
    if (in_cfg.mode == MODE_ENCODE) begin
      first_next  = in_d0 ^ in_d1;
      second_next = gf_mul(in_d0, GfTwo) ^ gf_mul(in_d1, GfThree);
    end else if (h0 && h1) begin
      first_next  = in_d0;
      second_next = in_d1;
    end else if (h0 && hp0) begin
      first_next  = in_d0;
      second_next = in_d0 ^ in_p0;
    end else if (h1 && hp0) begin
      first_next  = in_d1 ^ in_p0;
      second_next = in_d1;
    end else if (h0 && hp1) begin
      first_next  = in_d0;
      second_next = gf_mul(in_p1 ^ gf_mul(in_d0, GfTwo), GfInvThree);
    end else if (h1 && hp1) begin
      first_next  = gf_mul(in_p1 ^ gf_mul(in_d1, GfThree), GfInvTwo);
      second_next = in_d1;
    end else if (hp0 && hp1) begin
      second_next = in_p1 ^ gf_mul(in_p0, GfTwo);
      first_next  = in_p0 ^ second_next;
    end else begin
      flag_next = 1'b1;
    end
  end

  // Result register; the strobe is the input-stage strobe registered once more.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res_first  <= first_next;
      res_second <= second_next;
      res_flag   <= flag_next;
    end
  end

  assign done           = res_valid;
  assign out_first      = res_first;
  assign out_second     = res_second;
  assign too_few_pieces = res_flag;

endmodule

/* hdl/gf256_two_plus_two_erasure_codec_core.sv */
// Top level of the GF(2^8) two-data, two-parity erasure codec.
//
// A request is taken at each rising edge with start high and busy low. It
// carries the byte at one position of each piece: byte_data0, byte_data1,
// byte_parity0 and byte_parity1. busy is always low, so one request can be
// taken in every cycle.
// Its result is on out_first, out_second and too_few_pieces with done high
// for one cycle, once the request has passed the input and result registers
// around the GF logic.
// Sustained throughput is one request per cycle.
// Encode mode gives the XOR parity and the weighted parity. Recover mode
// rebuilds both data bytes from the first usable pair named by piece_mask;
// with fewer than two usable pieces it raises too_few_pieces and gives zeros.
// Configuration: cfg_wen, cfg_index and cfg_wdata write codec_mode (index 0)
// or piece_mask (index 1); write them only while no request is in flight.
// Synchronous reset drops requests in flight and sets encode mode with all
// four pieces usable. The receiver cannot stall: each result must be taken
// in the cycle that done is high.
module gf256_two_plus_two_erasure_codec_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [gf22_pkg::ByteW-1:0]      byte_data0,
  input  logic [gf22_pkg::ByteW-1:0]      byte_data1,
  input  logic [gf22_pkg::ByteW-1:0]      byte_parity0,
  input  logic [gf22_pkg::ByteW-1:0]      byte_parity1,
  output logic                            done,
  output logic [gf22_pkg::ByteW-1:0]      out_first,
  output logic [gf22_pkg::ByteW-1:0]      out_second,
  output logic                            too_few_pieces,
  input  logic                            cfg_wen,
  input  logic [gf22_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [gf22_pkg::CfgDataW-1:0]   cfg_wdata
);
  import gf22_pkg::*;

  cfg_t cfg;
  logic accept;

  // The datapath takes a new request in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  gf22_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gf22_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cfg            (cfg),
    .byte_data0     (byte_data0),
    .byte_data1     (byte_data1),
    .byte_parity0   (byte_parity0),
    .byte_parity1   (byte_parity1),
    .done           (done),
    .out_first      (out_first),
    .out_second     (out_second),
    .too_few_pieces (too_few_pieces)
  );

`ifndef NO_ASSERTIONS
  // Every result strobe belongs to a request that passed the input and result registers.
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a matching request");

  // A request taken with no reset in between yields its result through the input and result registers.
  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept ##1 !rst |=> done)
    else $error("accepted request produced no result");

  // A failed recovery gives zero bytes.
  a_flag_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    done && too_few_pieces |-> out_first == '0 && out_second == '0)
    else $error("too_few_pieces result carries nonzero bytes");
`endif

endmodule
